[src/serial_command_pwm_decoder_macros.svh]
// Assertion macros for the serial command PWM decoder.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef SERIAL_COMMAND_PWM_DECODER_MACROS_SVH
`define SERIAL_COMMAND_PWM_DECODER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SCPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scpd: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define SCPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scpd: next-cycle check failed");

`endif

[src/scpd_pkg.sv]
// Shared constants and types for the serial command PWM decoder.
// No dependencies; imported by every module of the block.
package scpd_pkg;

  localparam int BUFFER_SLOTS = 10;
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(BUFFER_SLOTS - 1);
  localparam int HEAD_SLOTS = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_TERM = 8'h2F;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_U = 8'h55;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_M = 8'h6D;
  localparam logic [7:0] CHAR_K = 8'h6B;
  localparam logic [15:0] DIGIT_ZERO = 16'd48;

  localparam logic [7:0] FEED_BITS = 8'b0000_0110;
  localparam logic [7:0] RIGHT_BIT = 8'b1000_0000;
  localparam logic [7:0] LEFT_BIT = 8'b0100_0000;
  localparam logic [7:0] UP_BIT = 8'b0010_0000;
  localparam logic [7:0] DOWN_BIT = 8'b0001_0000;
  localparam logic [7:0] STOP_MASK = 8'b0000_1111;
  localparam logic [7:0] TURN_MASK = 8'b1100_0000;
  localparam logic [7:0] LIFT_MASK = 8'b0011_0000;

  localparam logic [15:0] FEED_RESET = 16'd500;
  localparam logic [15:0] TURN_RESET = 16'd200;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FEED,
    OP_RIGHT,
    OP_LEFT,
    OP_UP,
    OP_DOWN,
    OP_STOP,
    OP_TURN_OFF,
    OP_LIFT_OFF
  } op_t;

  typedef struct packed {
    op_t op;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic pop;
  } q_ctl_t;

endpackage

[src/scpd_front.sv]
// Front end: tracks the write index, keeps the first four message bytes
// and classifies each byte into a command record. Depends on scpd_pkg.
module scpd_front (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] rx_byte,
  input  logic accept,
  output scpd_pkg::cmd_t cmd
);
  import scpd_pkg::*;

  logic [IDX_W-1:0] write_index;
  logic [7:0] message_head [HEAD_SLOTS];
  logic [7:0] head_next [HEAD_SLOTS];
  logic is_term;
  logic [15:0] a;
  logic [15:0] b;
  logic [15:0] c;
  logic [15:0] a_scaled;
  logic [15:0] b_scaled;
  op_t letter_op;

  assign is_term = (rx_byte == CHAR_TERM);

  always_comb begin
    for (int i = 0; i < HEAD_SLOTS; i++) begin
      if (write_index[IDX_W-1:2] == '0 && write_index[1:0] == 2'(i)) begin
        head_next[i] = rx_byte;
      end else begin
        head_next[i] = message_head[i];
      end
    end
  end

  assign a = {8'd0, head_next[1]} - DIGIT_ZERO;
  assign b = {8'd0, head_next[2]} - DIGIT_ZERO;
  assign c = {8'd0, head_next[3]} - DIGIT_ZERO;
  assign a_scaled = a * 16'd100;
  assign b_scaled = b * 16'd10;

  always_comb begin
    unique case (head_next[0])
      CHAR_F: letter_op = OP_FEED;
      CHAR_R: letter_op = OP_RIGHT;
      CHAR_L: letter_op = OP_LEFT;
      CHAR_U: letter_op = OP_UP;
      CHAR_D: letter_op = OP_DOWN;
      CHAR_S: letter_op = OP_STOP;
      CHAR_M: letter_op = OP_TURN_OFF;
      CHAR_K: letter_op = OP_LIFT_OFF;
      default: letter_op = OP_NONE;
    endcase
  end

  assign cmd.op = is_term ? letter_op : OP_NONE;
  assign cmd.value = a_scaled + b_scaled + c;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      for (int i = 0; i < HEAD_SLOTS; i++) begin
        message_head[i] <= 8'd0;
      end
    end else if (accept) begin
      for (int i = 0; i < HEAD_SLOTS; i++) begin
        message_head[i] <= head_next[i];
      end
      if (is_term || write_index >= LAST_SLOT) begin
        write_index <= '0;
      end else begin
        write_index <= write_index + IDX_W'(1);
      end
    end
  end

endmodule

[src/scpd_queue.sv]
// Short queue of command records between the front and back ends.
// Depends on scpd_pkg for the record type and the depth.
module scpd_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  scpd_pkg::cmd_t wr_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output scpd_pkg::cmd_t rd_data,
  output logic [scpd_pkg::QCNT_W-1:0] count
);
  import scpd_pkg::*;

  cmd_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic do_push;
  logic do_pop;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

[src/scpd_back.sv]
// Back end: applies command records to the port bits and duty values
// and holds one result for the output side. Depends on scpd_pkg.
module scpd_back (
  input  logic clk,
  input  logic rst,
  input  scpd_pkg::cmd_t cmd,
  input  scpd_pkg::q_ctl_t q_ctl,
  output logic take,
  output logic res_valid,
  output logic [7:0] control_bits,
  output logic [15:0] feed_duty,
  output logic [15:0] turn_duty,
  output logic applied
);
  import scpd_pkg::*;

  logic [7:0] port_bits;
  logic [15:0] duty_feed;
  logic [15:0] duty_turn;
  logic [7:0] port_bits_next;
  logic [15:0] duty_feed_next;
  logic [15:0] duty_turn_next;

  assign take = !q_ctl.empty && (!res_valid || q_ctl.pop);

  always_comb begin
    port_bits_next = port_bits;
    duty_feed_next = duty_feed;
    duty_turn_next = duty_turn;
    unique case (cmd.op)
      OP_FEED: begin
        duty_feed_next = cmd.value;
        port_bits_next = port_bits | FEED_BITS;
      end
      OP_RIGHT: begin
        duty_turn_next = cmd.value;
        port_bits_next = port_bits | RIGHT_BIT;
      end
      OP_LEFT: begin
        duty_turn_next = cmd.value;
        port_bits_next = port_bits | LEFT_BIT;
      end
      OP_UP: port_bits_next = port_bits | UP_BIT;
      OP_DOWN: port_bits_next = port_bits | DOWN_BIT;
      OP_STOP: port_bits_next = port_bits & ~STOP_MASK;
      OP_TURN_OFF: port_bits_next = port_bits & ~TURN_MASK;
      OP_LIFT_OFF: port_bits_next = port_bits & ~LIFT_MASK;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_bits <= 8'd0;
      duty_feed <= FEED_RESET;
      duty_turn <= TURN_RESET;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        port_bits <= port_bits_next;
        duty_feed <= duty_feed_next;
        duty_turn <= duty_turn_next;
        res_valid <= 1'b1;
      end else if (q_ctl.pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      control_bits <= port_bits_next;
      feed_duty <= duty_feed_next;
      turn_duty <= duty_turn_next;
      applied <= (cmd.op != OP_NONE);
    end
  end

endmodule

[src/serial_command_pwm_decoder.sv]
// Top level of the serial command PWM decoder: front end, command queue
// and back end. Depends on scpd_pkg and serial_command_pwm_decoder_macros.svh.
//
//   Channel   Handshake         Fields
//   input     push / full       rx_byte
//   result    pop / empty       control_bits, feed_duty, turn_duty, applied
//
// One byte per cycle is accepted while full is low, and one result per byte is produced.
// A byte's record is written into the command queue at its transfer in, then
// registered onto the result ports when the result side has room.
// Reset sets the index and head bytes to zero, the port bits to zero and the
// duties to 500 and 200. A stalled result side fills the two-entry queue,
// after which full stays high until a pop.
module serial_command_pwm_decoder (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] rx_byte,
  input  logic pop,
  output logic empty,
  output logic [7:0] control_bits,
  output logic [15:0] feed_duty,
  output logic [15:0] turn_duty,
  output logic applied
);
  import scpd_pkg::*;
  `include "serial_command_pwm_decoder_macros.svh"

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic accept;
  logic q_empty;
  logic q_take;
  logic res_valid;
  logic [QCNT_W-1:0] q_count;
  q_ctl_t q_ctl;

  assign accept = push && !full;
  assign empty = !res_valid;
  assign q_ctl.empty = q_empty;
  assign q_ctl.pop = pop && res_valid;

  scpd_front u_front (
    .clk(clk),
    .rst(rst),
    .rx_byte(rx_byte),
    .accept(accept),
    .cmd(front_cmd)
  );

  scpd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_data(front_cmd),
    .full(full),
    .pop(q_take),
    .empty(q_empty),
    .rd_data(q_cmd),
    .count(q_count)
  );

  scpd_back u_back (
    .clk(clk),
    .rst(rst),
    .cmd(q_cmd),
    .q_ctl(q_ctl),
    .take(q_take),
    .res_valid(res_valid),
    .control_bits(control_bits),
    .feed_duty(feed_duty),
    .turn_duty(turn_duty),
    .applied(applied)
  );

  `SCPD_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH))
  `SCPD_ASSERT_NEXT(a_transfer_lands, accept, !q_empty)
  `SCPD_ASSERT_NEXT(a_back_fills, q_take, !empty)
  `SCPD_ASSERT_NOW(a_take_needs_room, q_take, empty || pop)

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for serial_command_pwm_decoder: a queue-fed driver,
// a result monitor and a byte-level predictor of the command decoder.
// Depends on scpd_pkg and the RTL of the block only.
module tb_top;
  import scpd_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  typedef struct {
    logic [7:0] data;
    bit hold;
  } rx_item_t;

  typedef struct {
    logic [7:0] bits;
    logic [15:0] feed;
    logic [15:0] turn;
    logic applied;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [7:0] control_bits;
  logic [15:0] feed_duty;
  logic [15:0] turn_duty;
  logic applied;

  rx_item_t rx_q[$];
  status_t status_q[$];

  logic [IDX_W-1:0] slot_idx = '0;
  logic [7:0] head_bytes [HEAD_SLOTS] = '{default: 8'h00};
  logic [7:0] port_state = 8'h00;
  logic [15:0] feed_state = FEED_RESET;
  logic [15:0] turn_state = TURN_RESET;

  int sent_count = 0;
  int recv_count = 0;
  int send_gap = 0;
  int pop_gap = 0;
  bit send_steady = 1'b0;
  bit pop_steady = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;

  serial_command_pwm_decoder dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .pop(pop),
    .empty(empty),
    .control_bits(control_bits),
    .feed_duty(feed_duty),
    .turn_duty(turn_duty),
    .applied(applied)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(9, 4);
    return $urandom_range(40, 10);
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [15:0] value;
    status_t s;
    s.applied = 1'b0;
    if (slot_idx < HEAD_SLOTS) head_bytes[slot_idx[1:0]] = b;
    if (b == CHAR_TERM || slot_idx >= LAST_SLOT) slot_idx = '0;
    else slot_idx = slot_idx + 1'b1;
    if (b == CHAR_TERM) begin
      value = (16'(head_bytes[1]) - DIGIT_ZERO) * 16'd100
            + (16'(head_bytes[2]) - DIGIT_ZERO) * 16'd10
            + (16'(head_bytes[3]) - DIGIT_ZERO);
      s.applied = 1'b1;
      case (head_bytes[0])
        CHAR_F: begin
          feed_state = value;
          port_state = port_state | FEED_BITS;
        end
        CHAR_R: begin
          turn_state = value;
          port_state = port_state | RIGHT_BIT;
        end
        CHAR_L: begin
          turn_state = value;
          port_state = port_state | LEFT_BIT;
        end
        CHAR_U: port_state = port_state | UP_BIT;
        CHAR_D: port_state = port_state | DOWN_BIT;
        CHAR_S: port_state = port_state & ~STOP_MASK;
        CHAR_M: port_state = port_state & ~TURN_MASK;
        CHAR_K: port_state = port_state & ~LIFT_MASK;
        default: s.applied = 1'b0;
      endcase
    end
    s.bits = port_state;
    s.feed = feed_state;
    s.turn = turn_state;
    status_q.push_back(s);
  endtask

  task automatic add_byte(input logic [7:0] data, input bit hold = 1'b0);
    rx_item_t it;
    it.data = data;
    it.hold = hold;
    rx_q.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_random_message(input bit hold);
    logic [7:0] letters [8];
    logic [7:0] b;
    int extra;
    letters = '{CHAR_F, CHAR_R, CHAR_L, CHAR_U, CHAR_D, CHAR_S, CHAR_M, CHAR_K};
    if ($urandom_range(99) < 85) b = letters[$urandom_range(7)];
    else b = 8'($urandom_range(255));
    add_byte(b, hold);
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(9) != 0) b = 8'h30 + 8'($urandom_range(9));
      else b = 8'($urandom_range(255));
      add_byte(b);
    end
    if ($urandom_range(9) == 0) begin
      extra = $urandom_range(8, 1);
      for (int i = 0; i < extra; i++) begin
        b = 8'($urandom_range(255));
        if (b == CHAR_TERM) b = 8'h00;
        add_byte(b);
      end
    end
    add_byte(CHAR_TERM);
  endtask

  task automatic add_noise();
    int n;
    logic [7:0] b;
    n = $urandom_range(15, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) b = CHAR_TERM;
      else b = 8'($urandom_range(255));
      add_byte(b);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && full) begin
      push <= 1'b1;
    end else begin
      if (push) begin
        decode_byte(rx_byte);
        sent_count++;
        if ($urandom_range(49) == 0) send_steady = !send_steady;
        send_gap = pick_gap(send_steady);
      end else if (send_gap > 0) begin
        send_gap--;
      end
      if (send_gap == 0 && rx_q.size() > 0 &&
          !(rx_q[0].hold && sent_count != recv_count)) begin
        push <= 1'b1;
        rx_byte <= rx_q[0].data;
        rx_q.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    status_t exp_s;
    if (!rst) begin
      if (pop && !empty) begin
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected transfer out: bits=%h feed=%0d turn=%0d applied=%b",
                     control_bits, feed_duty, turn_duty, applied);
        end else begin
          exp_s = status_q.pop_front();
          if (control_bits !== exp_s.bits || feed_duty !== exp_s.feed ||
              turn_duty !== exp_s.turn || applied !== exp_s.applied) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch on result %0d: expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                       recv_count, exp_s.bits, exp_s.feed, exp_s.turn, exp_s.applied,
                       control_bits, feed_duty, turn_duty, applied);
          end
        end
        recv_count <= recv_count + 1;
        if ($urandom_range(49) == 0) pop_steady = !pop_steady;
        pop_gap = pick_gap(pop_steady);
      end else if (pop_gap > 0) begin
        pop_gap--;
      end
      pop <= (pop_gap == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int total;
    add_text("F999/");
    add_text("R000/");
    add_byte(CHAR_L);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(CHAR_TERM);
    add_text("U/D/S/m/k/");
    add_byte(CHAR_TERM);
    add_random_message(1'b1);
    while (rx_q.size() < 525) begin
      if ($urandom_range(99) < 80) add_random_message($urandom_range(19) == 0);
      else add_noise();
    end
    total = rx_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sent_count != total) @(posedge clk);
    while (recv_count != sent_count) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
